### hw/rtl/lcc_pkg.sv
// ============================================================================
// lcc_pkg: shared definitions for the largest connected component block
// Field widths, command codes and the default table depth.
// ============================================================================
package lcc_pkg;

    // Width of the vertex count, vertex number and size fields on the ports.
    localparam int FIELD_W = 11;

    // Default number of table entries.
    localparam int DEF_MAX_VERTICES = 1024;

    // Command codes carried by cmd.
    localparam logic CMD_START = 1'b0;
    localparam logic CMD_EDGE  = 1'b1;

endpackage

### hw/rtl/largest_connected_component.sv
// ============================================================================
// largest_connected_component: incremental union-find over an edge stream
// Tracks the size of the largest connected component of an undirected graph.
// ============================================================================
// An edge with an out-of-range vertex answers in the cycle after its request.
// A start request with N vertices (N saturated to the table depth) clears N table
// entries, one per cycle, then answers. A valid edge walks both root lookups and,
// when two components are merged, writes both roots; the single table read port,
// one access per cycle, sets the pace. Busy is high meanwhile.
// Reset clears all control state; a start request clears the active table range.
module largest_connected_component #(
    parameter int MAX_VERTICES = lcc_pkg::DEF_MAX_VERTICES
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic                        cmd,
    input  logic [lcc_pkg::FIELD_W-1:0] vertex_count,
    input  logic [lcc_pkg::FIELD_W-1:0] first_vertex,
    input  logic [lcc_pkg::FIELD_W-1:0] second_vertex,
    output logic                        done,
    output logic [lcc_pkg::FIELD_W-1:0] largest_size,
    output logic                        bad_vertex
);
    import lcc_pkg::*;

    // VW indexes the table, CW holds any size or count from 0 to MAX_VERTICES.
    // CMPW is wide enough to compare port fields against counts and sizes.
    localparam int VW   = $clog2(MAX_VERTICES);
    localparam int CW   = $clog2(MAX_VERTICES + 1);
    localparam int CMPW = (CW > FIELD_W) ? CW : FIELD_W;
    localparam int AW   = (VW > FIELD_W) ? VW : FIELD_W;
    localparam int EW   = VW + CW;

    // Sequencer states.
    localparam logic [2:0] S_IDLE       = 3'd0;
    localparam logic [2:0] S_CLEAR      = 3'd1;
    localparam logic [2:0] S_ROOT_CHECK = 3'd2;
    localparam logic [2:0] S_HALVE      = 3'd3;
    localparam logic [2:0] S_LINK_SMALL = 3'd4;
    localparam logic [2:0] S_LINK_BIG   = 3'd5;

    // Each table entry holds a parent link in its upper bits and a component
    // size in its lower bits. The size is meaningful only on a root entry.
    logic [EW-1:0] node_mem [MAX_VERTICES];
    logic [EW-1:0] mem_rd_reg;
    logic [VW-1:0] rd_addr;
    logic          wr_en;
    logic [VW-1:0] wr_addr;
    logic [EW-1:0] wr_data;

    logic [2:0]         state_reg, state_next;
    logic [CW-1:0]      active_reg, active_next;
    logic [CW-1:0]      largest_reg, largest_next;
    logic [VW-1:0]      clr_reg, clr_next;
    logic [VW-1:0]      x_reg, x_next;
    logic [CW-1:0]      x_size_reg, x_size_next;
    logic [VW-1:0]      b_idx_reg, b_idx_next;
    logic               second_reg, second_next;
    logic [VW-1:0]      root_a_reg, root_a_next;
    logic [CW-1:0]      size_a_reg, size_a_next;
    logic [CW-1:0]      size_b_reg, size_b_next;
    logic               done_reg, done_next;
    logic [FIELD_W-1:0] res_size_reg, res_size_next;
    logic               res_bad_reg, res_bad_next;

    logic               finish;
    logic [CMPW-1:0]    count_ext;
    logic [CMPW-1:0]    count_sat;
    logic [CMPW-1:0]    active_ext;
    logic               range_bad;
    logic [AW-1:0]      a_minus1;
    logic [AW-1:0]      b_minus1;
    logic [VW-1:0]      ent_parent;
    logic [CW-1:0]      ent_size;
    logic               b_is_big;
    logic [VW-1:0]      big_root;
    logic [VW-1:0]      small_root;
    logic [CW-1:0]      small_size;
    logic [CW-1:0]      total_size;
    logic [CMPW-1:0]    largest_wide;

    // The table has one write port and one registered read port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            node_mem[wr_addr] <= wr_data;
        end
        mem_rd_reg <= node_mem[rd_addr];
    end

    assign ent_parent = mem_rd_reg[EW-1:CW];
    assign ent_size   = mem_rd_reg[CW-1:0];

    // A vertex count above the table depth saturates to the depth.
    assign count_ext  = CMPW'(vertex_count);
    assign count_sat  = (count_ext > CMPW'(MAX_VERTICES)) ? CMPW'(MAX_VERTICES) : count_ext;
    assign active_ext = CMPW'(active_reg);

    // An edge is ignored when either end is zero or above the active count.
    // Before any start request the active count is zero, so every edge is bad.
    assign range_bad = (first_vertex == '0) || (second_vertex == '0) ||
                       (CMPW'(first_vertex) > active_ext) ||
                       (CMPW'(second_vertex) > active_ext);

    // Vertex numbers on the ports count from one; table indexes from zero.
    assign a_minus1 = AW'(first_vertex) - AW'(1);
    assign b_minus1 = AW'(second_vertex) - AW'(1);

    // Union by size: the root of the larger component stays a root, and the
    // first end's root wins a tie.
    assign b_is_big   = (size_b_reg > size_a_reg);
    assign big_root   = b_is_big ? x_reg : root_a_reg;
    assign small_root = b_is_big ? root_a_reg : x_reg;
    assign small_size = b_is_big ? size_a_reg : size_b_reg;
    assign total_size = size_a_reg + size_b_reg;

    always_comb
    begin
        state_next    = state_reg;
        active_next   = active_reg;
        largest_next  = largest_reg;
        clr_next      = clr_reg;
        x_next        = x_reg;
        x_size_next   = x_size_reg;
        b_idx_next    = b_idx_reg;
        second_next   = second_reg;
        root_a_next   = root_a_reg;
        size_a_next   = size_a_reg;
        size_b_next   = size_b_reg;
        res_bad_next  = res_bad_reg;
        finish        = 1'b0;
        rd_addr       = x_reg;
        wr_en         = 1'b0;
        wr_addr       = x_reg;
        wr_data       = {x_reg, x_size_reg};

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    if (cmd == CMD_START)
                    begin
                        active_next  = count_sat[CW-1:0];
                        largest_next = (count_sat != '0) ? CW'(1) : '0;
                        clr_next     = '0;
                        res_bad_next = 1'b0;
                        if (count_sat == '0)
                        begin
                            finish = 1'b1;
                        end
                        else
                        begin
                            state_next = S_CLEAR;
                        end
                    end
                    else if (range_bad)
                    begin
                        res_bad_next = 1'b1;
                        finish       = 1'b1;
                    end
                    else
                    begin
                        res_bad_next = 1'b0;
                        x_next       = a_minus1[VW-1:0];
                        b_idx_next   = b_minus1[VW-1:0];
                        second_next  = 1'b0;
                        rd_addr      = a_minus1[VW-1:0];
                        state_next   = S_ROOT_CHECK;
                    end
                end
            end

            S_CLEAR:
            begin
                // Only the active range is cleared; entries above it are never
                // read until a later start request clears them.
                wr_en    = 1'b1;
                wr_addr  = clr_reg;
                wr_data  = {clr_reg, CW'(1)};
                clr_next = clr_reg + VW'(1);
                if ((CW'(clr_reg) + CW'(1)) == active_reg)
                begin
                    finish     = 1'b1;
                    state_next = S_IDLE;
                end
            end

            S_ROOT_CHECK:
            begin
                if (ent_parent == x_reg)
                begin
                    if (!second_reg)
                    begin
                        root_a_next = x_reg;
                        size_a_next = ent_size;
                        second_next = 1'b1;
                        x_next      = b_idx_reg;
                        rd_addr     = b_idx_reg;
                    end
                    else
                    begin
                        size_b_next = ent_size;
                        if (x_reg == root_a_reg)
                        begin
                            finish     = 1'b1;
                            state_next = S_IDLE;
                        end
                        else
                        begin
                            state_next = S_LINK_SMALL;
                        end
                    end
                end
                else
                begin
                    x_size_next = ent_size;
                    rd_addr     = ent_parent;
                    state_next  = S_HALVE;
                end
            end

            S_HALVE:
            begin
                // Path halving: point the current vertex at its grandparent and
                // continue the walk from there.
                wr_en      = 1'b1;
                wr_addr    = x_reg;
                wr_data    = {ent_parent, x_size_reg};
                x_next     = ent_parent;
                rd_addr    = ent_parent;
                state_next = S_ROOT_CHECK;
            end

            S_LINK_SMALL:
            begin
                wr_en      = 1'b1;
                wr_addr    = small_root;
                wr_data    = {big_root, small_size};
                state_next = S_LINK_BIG;
            end

            S_LINK_BIG:
            begin
                wr_en   = 1'b1;
                wr_addr = big_root;
                wr_data = {big_root, total_size};
                if (total_size > largest_reg)
                begin
                    largest_next = total_size;
                end
                finish     = 1'b1;
                state_next = S_IDLE;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // The reported size is the tracked largest size masked to the port width.
    assign largest_wide  = CMPW'(largest_next);
    assign done_next     = finish;
    assign res_size_next = finish ? largest_wide[FIELD_W-1:0] : res_size_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            active_reg  <= '0;
            largest_reg <= '0;
            done_reg    <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            active_reg  <= active_next;
            largest_reg <= largest_next;
            done_reg    <= done_next;
        end
    end

    // Datapath registers need no reset.
    always_ff @(posedge clk)
    begin
        clr_reg      <= clr_next;
        x_reg        <= x_next;
        x_size_reg   <= x_size_next;
        b_idx_reg    <= b_idx_next;
        second_reg   <= second_next;
        root_a_reg   <= root_a_next;
        size_a_reg   <= size_a_next;
        size_b_reg   <= size_b_next;
        res_size_reg <= res_size_next;
        res_bad_reg  <= res_bad_next;
    end

    assign busy         = (state_reg != S_IDLE);
    assign done         = done_reg;
    assign largest_size = res_size_reg;
    assign bad_vertex   = res_bad_reg;

    // The largest component can never hold more vertices than the graph has.
    a_largest_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        largest_reg <= active_reg)
        else $error("largest component size exceeds the active vertex count");

    // A result strobe only ever appears once the sequencer is back at rest.
    a_done_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE) |-> !done_reg)
        else $error("result strobe raised while the sequencer is busy");

    // Merging is only entered with two distinct roots.
    a_link_distinct: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_LINK_SMALL) |-> (x_reg != root_a_reg))
        else $error("merge started on a single root");

    // The clearing sweep stays inside the active range.
    a_clear_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CLEAR) |-> (CW'(clr_reg) < active_reg))
        else $error("clearing sweep ran past the active range");

endmodule
